// File: design/tcw_pkg.sv
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = 11;
  localparam int CELL_W = 16;
  localparam int REQ_W  = 3;

  // request codes
  localparam logic [REQ_W-1:0] REQ_PUT   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_LEFT  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_RIGHT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ  = 3'd4;

  // control characters
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] BLANK_ATTR_RST = 8'h0F;

  // decoded request from the cursor unit to the sequencer
  typedef struct packed {
    logic [COL_W-1:0]  col_nxt;
    logic [ROW_W-1:0]  row_nxt;
    logic [ADDR_W-1:0] pos_nxt;
    logic              wr_en;
    logic              wr_blank;
    logic [ADDR_W-1:0] wr_addr;
    logic              scroll;
    logic              clear;
    logic              read;
  } tcw_cmd_t;

endpackage

// File: design/tcw_ram.sv
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/tcw_cursor.sv
module tcw_cursor (
  input  logic [tcw_pkg::COL_W-1:0] col,
  input  logic [tcw_pkg::ROW_W-1:0] row,
  input  logic [tcw_pkg::REQ_W-1:0] req_type,
  input  logic [7:0]                char_code,
  output tcw_pkg::tcw_cmd_t         cmd
);

  localparam logic [tcw_pkg::COL_W-1:0] COL_LAST = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
  localparam logic [tcw_pkg::ROW_W-1:0] ROW_LAST = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
  localparam logic [tcw_pkg::ADDR_W-1:0] COLS_A = tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);

  logic [tcw_pkg::COL_W-1:0]  col_dec;
  logic [tcw_pkg::ADDR_W-1:0] row_base;

  assign col_dec  = (col == '0) ? '0 : col - 1'b1;
  assign row_base = tcw_pkg::ADDR_W'(row) * COLS_A;

  always_comb begin
    cmd          = '0;
    cmd.col_nxt  = col;
    cmd.row_nxt  = row;
    case (req_type)
      tcw_pkg::REQ_PUT: begin
        if (char_code == tcw_pkg::CH_LF) begin
          cmd.col_nxt = '0;
          if (row == ROW_LAST) cmd.scroll = 1'b1;
          else                 cmd.row_nxt = row + 1'b1;
        end else if (char_code == tcw_pkg::CH_CR) begin
          cmd.col_nxt = '0;
        end else if (char_code == tcw_pkg::CH_BS) begin
          cmd.col_nxt  = col_dec;
          cmd.wr_en    = 1'b1;
          cmd.wr_blank = 1'b1;
          cmd.wr_addr  = row_base + tcw_pkg::ADDR_W'(col_dec);
        end else begin
          cmd.wr_en   = 1'b1;
          cmd.wr_addr = row_base + tcw_pkg::ADDR_W'(col);
          if (col == COL_LAST) begin
            cmd.col_nxt = '0;
            if (row == ROW_LAST) cmd.scroll = 1'b1;
            else                 cmd.row_nxt = row + 1'b1;
          end else begin
            cmd.col_nxt = col + 1'b1;
          end
        end
      end
      tcw_pkg::REQ_LEFT:  cmd.col_nxt = col_dec;
      tcw_pkg::REQ_RIGHT: begin
        if (col < COL_LAST) cmd.col_nxt = col + 1'b1;
      end
      tcw_pkg::REQ_CLEAR: begin
        cmd.col_nxt = '0;
        cmd.row_nxt = '0;
        cmd.clear   = 1'b1;
      end
      tcw_pkg::REQ_READ:  cmd.read = 1'b1;
      default: ;
    endcase
    // hardware cursor register value after the request
    cmd.pos_nxt = tcw_pkg::ADDR_W'(cmd.row_nxt) * COLS_A + tcw_pkg::ADDR_W'(cmd.col_nxt);
  end

endmodule

// File: design/text_console_writer_core.sv
// Channel   Direction  Transfer moves
// in_*      slave      one request: tuser = req_type, tdata = char, colours, cell index
// out_*     master     one result per request: cursor column, row, position, read data
// cfg_*     write      blank_attribute, taken on any clock edge out of reset with cfg_wr_en high
//
// Cursor moves, carriage return, backspace and printable characters without scroll
// finish as they are accepted; read cell goes through the read state, as the cell
// RAM read is registered. A scroll walks the cell RAM port, copying each row from the
// second one row up and then blanking the bottom row; clear writes one cell a cycle.
// Reset clears the cursor, the sequencer and the result register; cell contents stay
// undefined until written. in_tready is low while a request is at work and while an
// untaken result would be overwritten; a waiting result holds until out_tready.
module text_console_writer_core (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] char_code, [11:8] back_color, [15:12] fore_color, [26:16] cell_index
  input  logic [31:0] in_tdata,
  // [2:0] req_type
  input  logic [2:0]  in_tuser,

  output logic        out_tvalid,
  input  logic        out_tready,
  // [6:0] cursor_col, [11:7] cursor_row, [22:12] cursor_pos, [38:23] read_data
  output logic [39:0] out_tdata,

  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  localparam int AW = tcw_pkg::ADDR_W;
  localparam int CW = tcw_pkg::CELL_W;

  localparam logic [AW-1:0] CELLS_A     = AW'(tcw_pkg::CELLS);
  localparam logic [AW-1:0] LAST_A      = AW'(tcw_pkg::CELLS - 1);
  localparam logic [AW-1:0] COLS_A      = AW'(tcw_pkg::COLUMNS);
  localparam logic [AW-1:0] FILL_BASE_A = AW'(tcw_pkg::COLUMNS * (tcw_pkg::ROWS - 1));

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_SCROLL = 2'd2;
  localparam logic [1:0] ST_FILL   = 2'd3;

  logic [1:0]                state_r, state_nxt;
  logic [tcw_pkg::COL_W-1:0] col_r, col_nxt;
  logic [tcw_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [AW-1:0]             pos_r, pos_nxt;
  logic [AW-1:0]             cnt_r, cnt_nxt;
  logic                      pend_r, pend_nxt;
  logic [AW-1:0]             pend_addr_r, pend_addr_nxt;
  logic                      rd_ok_r, rd_ok_nxt;
  logic [7:0]                blank_attr_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [39:0]               out_data_r, out_data_nxt;

  logic [tcw_pkg::REQ_W-1:0] req_type;
  logic [7:0]                char_code;
  logic [3:0]                back_color;
  logic [3:0]                fore_color;
  logic [AW-1:0]             cell_index;

  tcw_pkg::tcw_cmd_t cmd;

  logic          in_accept;
  logic [CW-1:0] blank_cell;
  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic [CW-1:0] ram_wr_data;
  logic [AW-1:0] ram_rd_addr;
  logic [CW-1:0] ram_rd_data;

  assign req_type   = in_tuser;
  assign char_code  = in_tdata[7:0];
  assign back_color = in_tdata[11:8];
  assign fore_color = in_tdata[15:12];
  assign cell_index = in_tdata[26:16];

  assign blank_cell = {blank_attr_r, tcw_pkg::CH_SPACE};

  // accept only when idle and the result register is free or emptying now
  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_accept = in_tvalid && in_tready;

  tcw_cursor u_cursor (
    .col       (col_r),
    .row       (row_r),
    .req_type  (req_type),
    .char_code (char_code),
    .cmd       (cmd)
  );

  // one write port shared by the character write, the scroll copy and the fill
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = cmd.wr_addr;
    ram_wr_data = cmd.wr_blank ? blank_cell : {back_color, fore_color, char_code};
    ram_rd_addr = cell_index;
    case (state_r)
      ST_IDLE: ram_wr_en = in_accept && cmd.wr_en;
      ST_SCROLL: begin
        ram_rd_addr = cnt_r;
        ram_wr_en   = pend_r;
        ram_wr_addr = pend_addr_r;
        ram_wr_data = ram_rd_data;
      end
      ST_FILL: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = cnt_r;
        ram_wr_data = blank_cell;
      end
      default: ;
    endcase
  end

  tcw_ram #(
    .WIDTH (CW),
    .DEPTH (tcw_pkg::CELLS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          col_nxt   = cmd.col_nxt;
          row_nxt   = cmd.row_nxt;
          pos_nxt   = cmd.pos_nxt;
          rd_ok_nxt = cell_index < CELLS_A;
          if (cmd.read) begin
            state_nxt = ST_READ;
          end else if (cmd.scroll) begin
            // start copying from the second row
            state_nxt = ST_SCROLL;
            cnt_nxt   = COLS_A;
          end else if (cmd.clear) begin
            state_nxt = ST_FILL;
            cnt_nxt   = '0;
          end else begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = {1'b0, {CW{1'b0}}, cmd.pos_nxt, cmd.row_nxt, cmd.col_nxt};
          end
        end
      end
      ST_READ: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        out_data_nxt  = {1'b0, rd_ok_r ? ram_rd_data : {CW{1'b0}}, pos_r, row_r, col_r};
      end
      ST_SCROLL: begin
        // read cell cnt, write it one row up in the next cycle; the count runs
        // one past the last cell to drain the final pending write
        if (cnt_r == CELLS_A) begin
          state_nxt = ST_FILL;
          cnt_nxt   = FILL_BASE_A;
        end else begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = cnt_r - COLS_A;
          cnt_nxt       = cnt_r + 1'b1;
        end
      end
      ST_FILL: begin
        if (cnt_r == LAST_A) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, {CW{1'b0}}, pos_r, row_r, col_r};
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      col_r        <= '0;
      row_r        <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      blank_attr_r <= tcw_pkg::BLANK_ATTR_RST;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) blank_attr_r <= cfg_wr_data;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    cnt_r       <= cnt_nxt;
    pend_addr_r <= pend_addr_nxt;
    rd_ok_r     <= rd_ok_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: design/tcw_checker.sv
module tcw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed under stall");

  // the cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[6:0] < tcw_pkg::COLUMNS) && (out_tdata[11:7] < tcw_pkg::ROWS))
    else $error("cursor off screen");

  // the cursor register matches row and column
  a_cursor_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[22:12] ==
      11'(out_tdata[11:7] * tcw_pkg::COLUMNS + out_tdata[6:0]))
    else $error("cursor position inconsistent");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: dv/text_console_writer_core_test.sv
module text_console_writer_core_test;
  import tcw_pkg::*;

  // Request codes above REQ_READ are spare: the block must leave its state alone.
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;
  localparam int ADDR_MAX = 2 ** ADDR_W - 1;
  localparam int PHASES = 5;
  localparam int ITEMS_PER_PHASE = 60;

  // One request as it travels on in_*; packed so that the fields read naturally.
  typedef struct packed {
    logic [REQ_W-1:0]  kind;
    logic [ADDR_W-1:0] idx;
    logic [3:0]        fore;
    logic [3:0]        back;
    logic [7:0]        ch;
  } console_req_t;

  // One result; layout matches out_tdata[38:0], cursor column in the low bits.
  typedef struct packed {
    logic [CELL_W-1:0] data;
    logic [ADDR_W-1:0] pos;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } console_result_t;

  // A row of the directed stimulus: optional attribute write first, then the
  // request sent reps times; a hand-typed result checks the last transfer only.
  typedef struct {
    bit              cfg_en;
    logic [7:0]      cfg_val;
    console_req_t    q;
    int              reps;
    bit              typed;
    console_result_t res;
  } console_step_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [7:0] char_code, [11:8] back_color, [15:12] fore_color,
                           // [26:16] cell_index, [31:27] zero
  logic [2:0]  in_tuser;   // [2:0] req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [6:0] cursor_col, [11:7] cursor_row, [22:12] cursor_pos,
                           // [38:23] read_data, [39] zero
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;

  text_console_writer_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Console image kept by the testbench. cell_known marks cells written since
  // reset; reads are steered away from the rest, whose contents are undefined.
  // ---------------------------------------------------------------------------
  logic [CELL_W-1:0] screen_img [CELLS];
  bit                cell_known [CELLS];
  int unsigned       cur_col;
  int unsigned       cur_row;
  logic [7:0]        blank_attr;

  console_result_t   pending_results [$];
  console_step_t     directed_steps [$];
  int unsigned       fails = 0;
  bit                sender_calm = 1'b0;

  function automatic logic [CELL_W-1:0] blank_word();
    return {blank_attr, CH_SPACE};
  endfunction

  task automatic store_cell(input int unsigned a, input logic [CELL_W-1:0] w);
    screen_img[a] = w;
    cell_known[a] = 1'b1;
  endtask

  // Move every row up by one and fill the bottom row with blanks; the
  // written marks travel with the cells.
  task automatic scroll_screen();
    for (int i = COLUMNS; i < CELLS; i++) begin
      screen_img[i - COLUMNS] = screen_img[i];
      cell_known[i - COLUMNS] = cell_known[i];
    end
    for (int i = CELLS - COLUMNS; i < CELLS; i++) store_cell(i, blank_word());
    cur_row = ROWS - 1;
  endtask

  // Advance the console image by one accepted request and give its result.
  task automatic apply_request(input console_req_t q, output console_result_t r);
    logic [CELL_W-1:0] rd;
    int unsigned       p;
    rd = '0;
    case (q.kind)
      REQ_PUT: begin
        if (q.ch == CH_LF) begin
          cur_row++;
          cur_col = 0;
          if (cur_row >= ROWS) scroll_screen();
        end else if (q.ch == CH_CR) begin
          cur_col = 0;
        end else if (q.ch == CH_BS) begin
          // step left first, then blank whatever the cursor now sits on
          if (cur_col != 0) cur_col--;
          store_cell(cur_row * COLUMNS + cur_col, blank_word());
        end else begin
          store_cell(cur_row * COLUMNS + cur_col, {q.back, q.fore, q.ch});
          cur_col++;
          if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= ROWS) scroll_screen();
          end
        end
      end
      REQ_LEFT:  if (cur_col != 0) cur_col--;
      REQ_RIGHT: if (cur_col < COLUMNS - 1) cur_col++;
      REQ_CLEAR: begin
        for (int i = 0; i < CELLS; i++) store_cell(i, blank_word());
        cur_col = 0;
        cur_row = 0;
      end
      REQ_READ:  if (q.idx < CELLS) rd = screen_img[q.idx];
      default: ;
    endcase
    p = cur_row * COLUMNS + cur_col;
    r.col  = COL_W'(cur_col);
    r.row  = ROW_W'(cur_row);
    r.pos  = ADDR_W'(p);
    r.data = rd;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic console_req_t req_of(logic [REQ_W-1:0] kind, logic [7:0] ch,
                                          logic [3:0] back, logic [3:0] fore, int idx);
    console_req_t q;
    q.kind = kind;
    q.ch   = ch;
    q.back = back;
    q.fore = fore;
    q.idx  = ADDR_W'(idx);
    return q;
  endfunction

  function automatic console_result_t res_of(int col, int row, int pos,
                                             logic [CELL_W-1:0] data);
    console_result_t r;
    r.col  = COL_W'(col);
    r.row  = ROW_W'(row);
    r.pos  = ADDR_W'(pos);
    r.data = data;
    return r;
  endfunction

  task automatic add_step(input bit cfg_en, input logic [7:0] cfg_val, input console_req_t q,
                          input int reps, input bit typed, input console_result_t res);
    console_step_t s;
    s.cfg_en  = cfg_en;
    s.cfg_val = cfg_val;
    s.q       = q;
    s.reps    = reps;
    s.typed   = typed;
    s.res     = res;
    directed_steps.push_back(s);
  endtask

  // Mostly near the cursor or anywhere on screen, sometimes past the end.
  // Never aim at a cell that has not been written since reset.
  function automatic logic [ADDR_W-1:0] pick_read_addr();
    int unsigned a;
    int unsigned c;
    int unsigned r;
    c = cur_row * COLUMNS + cur_col;
    r = $urandom_range(0, 19);
    if (r < 8)       a = (c >= 3) ? c - $urandom_range(0, 3) : c;
    else if (r < 17) a = $urandom_range(0, CELLS - 1);
    else             a = $urandom_range(CELLS, ADDR_MAX);
    if (a < CELLS && !cell_known[a]) a = $urandom_range(CELLS, ADDR_MAX);
    return ADDR_W'(a);
  endfunction

  function automatic console_req_t make_req(logic [REQ_W-1:0] kind, logic [7:0] ch);
    console_req_t q;
    q.kind = kind;
    q.ch   = ch;
    q.back = 4'($urandom_range(0, 15));
    q.fore = 4'($urandom_range(0, 15));
    q.idx  = (kind == REQ_READ) ? pick_read_addr() : ADDR_W'($urandom_range(0, ADDR_MAX));
    return q;
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one; none in calm stretches.
  function automatic int unsigned sender_gap();
    int unsigned r;
    if (sender_calm) return 0;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 16) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one request, hold it until the transfer, then record what must come back.
  // Valid stays high across back-to-back requests: one assignment per edge.
  task automatic send_request(input console_req_t q, input bit typed,
                              input console_result_t typed_res);
    console_result_t pred;
    int unsigned     gap;
    gap = sender_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, q.idx, q.fore, q.back, q.ch};
    in_tuser  <= q.kind;
    do @(posedge clk); while (!in_tready);
    apply_request(q, pred);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  task automatic send_random(input logic [REQ_W-1:0] kind, input logic [7:0] ch,
                             inout int unsigned n);
    send_request(make_req(kind, ch), 1'b0, '0);
    // spare codes leave cursor and cells alone but still return a result: do not count them
    if (kind <= REQ_READ) n++;
  endtask

  // Drop valid and hold off until every result has been taken.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Attribute writes happen only with the block idle.
  task automatic write_blank_attr(input logic [7:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    blank_attr = v;
  endtask

  // One burst of random traffic. Lines of text and runs of newlines dominate so
  // that the cursor reaches the bottom row and scrolling gets plenty of use.
  task automatic random_burst(inout int unsigned n);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 29) == 0) sender_calm = !sender_calm;
    if (pick < 45) begin
      // a line of text: short mostly, sometimes long enough to wrap
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 12))
        send_random(REQ_PUT, 8'($urandom_range(0, 255)), n);
      case ($urandom_range(0, 9))
        0, 1:    send_random(REQ_PUT, CH_CR, n);
        2:       ;
        default: send_random(REQ_PUT, CH_LF, n);
      endcase
    end else if (pick < 55) begin
      repeat ($urandom_range(5, 30)) send_random(REQ_PUT, CH_LF, n);
    end else if (pick < 67) begin
      // a long run to the right edge, or a few steps either way
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(70, 90)) send_random(REQ_RIGHT, 8'($urandom_range(0, 255)), n);
      else
        repeat ($urandom_range(1, 8))
          send_random(($urandom_range(0, 1) == 0) ? REQ_LEFT : REQ_RIGHT,
                      8'($urandom_range(0, 255)), n);
    end else if (pick < 75) begin
      repeat ($urandom_range(1, 6)) send_random(REQ_PUT, CH_BS, n);
    end else if (pick < 88) begin
      repeat ($urandom_range(1, 4)) send_random(REQ_READ, 8'($urandom_range(0, 255)), n);
    end else if (pick < 90) begin
      send_random(REQ_CLEAR, 8'($urandom_range(0, 255)), n);
    end else if (pick < 95) begin
      send_random(REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)),
                  8'($urandom_range(0, 255)), n);
    end else begin
      // noise: any valid code with any content
      send_random(REQ_W'($urandom_range(REQ_PUT, REQ_READ)), 8'($urandom_range(0, 255)), n);
    end
  endtask

  // Directed part. Cursor values and blank cells that follow at a glance are
  // typed in; the rest is left to the image above.
  task automatic build_directed();
    // printable character, then read it straight back
    add_step(0, 8'h00, req_of(REQ_PUT, 8'h41, 4'hF, 4'h0, 0), 1, 1, res_of(1, 0, 1, 16'h0000));
    add_step(0, 8'h00, req_of(REQ_READ, 8'h00, 4'h0, 4'h0, 0), 1, 1, res_of(1, 0, 1, 16'hF041));
    add_step(0, 8'h00, req_of(REQ_PUT, 8'hFF, 4'h0, 4'hF, ADDR_MAX), 1, 0, '0);
    add_step(0, 8'h00, req_of(REQ_READ, 8'h00, 4'h0, 4'h0, 1), 1, 0, '0);
    add_step(0, 8'h00, req_of(REQ_LEFT, 8'h00, 4'h0, 4'h0, 0), 1, 0, '0);
    // backspace away from the left edge steps left and blanks
    add_step(0, 8'h00, req_of(REQ_PUT, CH_BS, 4'h0, 4'h0, 0), 1, 0, '0);
    add_step(0, 8'h00, req_of(REQ_READ, 8'h00, 4'h0, 4'h0, 0), 1, 1,
             res_of(0, 0, 0, {BLANK_ATTR_RST, CH_SPACE}));
    // left edge: cursor left holds, backspace blanks in place
    add_step(0, 8'h00, req_of(REQ_LEFT, 8'h00, 4'h0, 4'h0, 0), 1, 1, res_of(0, 0, 0, 16'h0000));
    add_step(0, 8'h00, req_of(REQ_PUT, CH_BS, 4'h0, 4'h0, 0), 1, 1, res_of(0, 0, 0, 16'h0000));
    add_step(0, 8'h00, req_of(REQ_PUT, 8'h61, 4'h1, 4'h2, 0), 1, 0, '0);
    add_step(0, 8'h00, req_of(REQ_PUT, CH_CR, 4'h0, 4'h0, 0), 1, 1, res_of(0, 0, 0, 16'h0000));
    // clear, then reads at the last cell and beyond the screen
    add_step(0, 8'h00, req_of(REQ_CLEAR, 8'h00, 4'h0, 4'h0, 0), 1, 1, res_of(0, 0, 0, 16'h0000));
    add_step(0, 8'h00, req_of(REQ_READ, 8'h00, 4'h0, 4'h0, CELLS - 1), 1, 1,
             res_of(0, 0, 0, {BLANK_ATTR_RST, CH_SPACE}));
    add_step(0, 8'h00, req_of(REQ_READ, 8'h00, 4'h0, 4'h0, CELLS), 1, 1,
             res_of(0, 0, 0, 16'h0000));
    add_step(0, 8'h00, req_of(REQ_READ, 8'hFF, 4'hF, 4'hF, ADDR_MAX), 1, 1,
             res_of(0, 0, 0, 16'h0000));
    // spare codes change nothing
    add_step(0, 8'h00, req_of(REQ_SPARE_LO, 8'h00, 4'h0, 4'h0, 0), 1, 1,
             res_of(0, 0, 0, 16'h0000));
    add_step(0, 8'h00, req_of(REQ_SPARE_HI, 8'hFF, 4'hF, 4'hF, ADDR_MAX), 1, 1,
             res_of(0, 0, 0, 16'h0000));
    // right edge, then a character in the last column wraps the line
    add_step(0, 8'h00, req_of(REQ_PUT, CH_LF, 4'h0, 4'h0, 0), 1, 1, res_of(0, 1, 80, 16'h0000));
    add_step(0, 8'h00, req_of(REQ_RIGHT, 8'h00, 4'h0, 4'h0, 0), COLUMNS - 1, 0, '0);
    add_step(0, 8'h00, req_of(REQ_RIGHT, 8'h00, 4'h0, 4'h0, 0), 1, 1,
             res_of(79, 1, 159, 16'h0000));
    add_step(0, 8'h00, req_of(REQ_PUT, 8'h5A, 4'h3, 4'hC, 0), 1, 1, res_of(0, 2, 160, 16'h0000));
    // newlines down to the bottom row, one more scrolls
    add_step(0, 8'h00, req_of(REQ_PUT, CH_LF, 4'h0, 4'h0, 0), ROWS - 3, 0, '0);
    add_step(0, 8'h00, req_of(REQ_PUT, CH_LF, 4'h0, 4'h0, 0), 1, 1,
             res_of(0, 24, 1920, 16'h0000));
    add_step(0, 8'h00, req_of(REQ_READ, 8'h00, 4'h0, 4'h0, 79), 1, 0, '0);
    add_step(0, 8'h00, req_of(REQ_READ, 8'h00, 4'h0, 4'h0, 1920), 1, 1,
             res_of(0, 24, 1920, {BLANK_ATTR_RST, CH_SPACE}));
    // attribute extremes seen through clear and backspace
    add_step(1, 8'hFF, req_of(REQ_CLEAR, 8'h00, 4'h0, 4'h0, 0), 1, 1, res_of(0, 0, 0, 16'h0000));
    add_step(0, 8'h00, req_of(REQ_READ, 8'h00, 4'h0, 4'h0, 0), 1, 1, res_of(0, 0, 0, 16'hFF20));
    add_step(1, 8'h00, req_of(REQ_PUT, CH_BS, 4'h0, 4'h0, 0), 1, 1, res_of(0, 0, 0, 16'h0000));
    add_step(0, 8'h00, req_of(REQ_READ, 8'h00, 4'h0, 4'h0, 0), 1, 1, res_of(0, 0, 0, 16'h0020));
  endtask

  // ---------------------------------------------------------------------------
  // Sender: reset, directed rows, then random phases under differing attributes
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    console_step_t st;
    int unsigned   done_items;
    logic [7:0]    phase_attr [PHASES];
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    cur_col     = 0;
    cur_row     = 0;
    blank_attr  = BLANK_ATTR_RST;
    for (int i = 0; i < CELLS; i++) cell_known[i] = 1'b0;
    build_directed();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[i]) begin
      st = directed_steps[i];
      if (st.cfg_en) write_blank_attr(st.cfg_val);
      for (int r = 0; r < st.reps; r++) send_request(st.q, st.typed && (r == st.reps - 1), st.res);
    end

    phase_attr[0] = 8'h00;
    phase_attr[1] = 8'hFF;
    for (int p = 2; p < PHASES; p++) phase_attr[p] = 8'($urandom_range(0, 255));
    for (int p = 0; p < PHASES; p++) begin
      // each attribute write also makes the sender wait for a full drain
      write_blank_attr(phase_attr[p]);
      done_items = 0;
      while (done_items < ITEMS_PER_PHASE) random_burst(done_items);
    end

    wait_drained();
    // leave room for any stray transfer to show up
    repeat (50) @(posedge clk);
    if (fails == 0) $display("text_console_writer_core test passed");
    else $display("text_console_writer_core test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: bursts of ready, short and long stalls, and long calm stretches
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned r;
    int unsigned len;
    out_tready = 1'b0;
    forever begin
      r = $urandom_range(0, 19);
      if (r < 10) begin
        out_tready <= 1'b1;
        len = $urandom_range(1, 20);
      end else if (r < 15) begin
        out_tready <= 1'b0;
        len = $urandom_range(1, 3);
      end else if (r < 17) begin
        out_tready <= 1'b0;
        len = $urandom_range(8, 60);
      end else begin
        out_tready <= 1'b1;
        len = $urandom_range(100, 400);
      end
      repeat (len) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: each result transfer against the oldest pending expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    console_result_t got;
    console_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[38:0];
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing pending: col %0d row %0d pos %0d data %h",
               got.col, got.row, got.pos, got.data);
        fails++;
      end else begin
        want = pending_results.pop_front();
        if (got.col != want.col) begin
          $error("cursor_col: expected %0d, got %0d", want.col, got.col);
          fails++;
        end
        if (got.row != want.row) begin
          $error("cursor_row: expected %0d, got %0d", want.row, got.row);
          fails++;
        end
        if (got.pos != want.pos) begin
          $error("cursor_pos: expected %0d, got %0d", want.pos, got.pos);
          fails++;
        end
        if (got.data !== want.data) begin
          $error("read_data: expected %h, got %h", want.data, got.data);
          fails++;
        end
      end
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #200_000_000;
    $display("text_console_writer_core test failed");
    $finish;
  end

endmodule
